@@ rtl/core/dm1bam_pkg.sv @@
// dm1bam_pkg: shared constants, command types and identifiers for the
// dm1 broadcast reassembly and trouble-code decoder. No dependencies.
package dm1bam_pkg;

  localparam int MESSAGE_BYTES   = 42;
  localparam int SOURCE_COUNT    = 2;
  localparam int ROW_BYTES       = 7;
  localparam int ROWS_PER_SOURCE = (MESSAGE_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int ROW_COUNT       = SOURCE_COUNT * ROWS_PER_SOURCE;
  localparam int ROW_ADDR_W      = $clog2(ROW_COUNT);
  localparam int ROW_IDX_W       = $clog2(ROWS_PER_SOURCE);
  localparam int LINE_BYTES      = ROWS_PER_SOURCE * ROW_BYTES;
  localparam int SLOT_LIMIT      = 10;
  localparam int MAX_SLOTS       = ((MESSAGE_BYTES - 2) / 4 > SLOT_LIMIT) ?
                                   SLOT_LIMIT : (MESSAGE_BYTES - 2) / 4;
  localparam int CMD_DEPTH       = 2;
  localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);
  localparam int CFG_INDEX_W     = 2;

  // identifier bits above the source address
  localparam logic [20:0] SINGLE_ID_HI   = 21'h18FECA;
  localparam logic [20:0] ANNOUNCE_ID_HI = 21'h1CECFF;
  localparam logic [20:0] DATA_ID_HI     = 21'h1CEBFF;

  localparam logic [7:0] TP_CM_BAM     = 8'h20;
  localparam logic [7:0] PGN_LOW       = 8'hCA;
  localparam logic [7:0] PGN_MID       = 8'hFE;
  localparam logic [7:0] SPN_HIGH_MASK = 8'hE0;
  localparam logic [7:0] FMI_MASK      = 8'h1F;
  localparam logic [5:0] SINGLE_FRAME_LEN = 6'd6;

  localparam logic [7:0] SOURCE_A_RESET = 8'd239;
  localparam logic [7:0] SOURCE_B_RESET = 8'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_A = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_B = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    CMD_SINGLE,
    CMD_CLEAR,
    CMD_DATA
  } cmd_op_t;

  typedef logic [ROW_BYTES-1:0][7:0] row_t;

  typedef struct packed {
    cmd_op_t                op;
    logic                   src;
    logic                   store;
    logic                   finish;
    logic [ROW_IDX_W-1:0]   row;
    logic [5:0]             length;
    row_t                   payload;
  } cmd_t;

endpackage

@@ rtl/core/dm1bam_if.sv @@
// dm1bam_if: valid/ready channel interfaces for frames, results and config.
// Depends on dm1bam_pkg for the config index width.
interface dm1bam_frame_if ();
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [7:0]  data_byte0;
  logic [7:0]  data_byte1;
  logic [7:0]  data_byte2;
  logic [7:0]  data_byte3;
  logic [7:0]  data_byte4;
  logic [7:0]  data_byte5;
  logic [7:0]  data_byte6;
  logic [7:0]  data_byte7;

  modport source (
    output valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6, data_byte7,
    input  ready
  );
  modport sink (
    input  valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6, data_byte7,
    output ready
  );
endinterface

interface dm1bam_result_if ();
  logic        valid;
  logic        ready;
  logic        source_select;
  logic [5:0]  message_length;
  logic [7:0]  lamp_status;
  logic [3:0]  dtc_index;
  logic [18:0] suspect_number;
  logic [4:0]  failure_mode;
  logic        dtc_present;
  logic        last;

  modport source (
    output valid, source_select, message_length, lamp_status, dtc_index,
           suspect_number, failure_mode, dtc_present, last,
    input  ready
  );
  modport sink (
    input  valid, source_select, message_length, lamp_status, dtc_index,
           suspect_number, failure_mode, dtc_present, last,
    output ready
  );
endinterface

interface dm1bam_cfg_if import dm1bam_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/dm1bam_front.sv @@
// dm1bam_front: accepts frames, matches identifiers, tracks per-source
// announce state and issues commands. Depends on dm1bam_pkg, dm1bam_if.
module dm1bam_front import dm1bam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  dm1bam_frame_if.sink     frame,
  dm1bam_cfg_if.sink       cfg,
  input  logic             cmd_full,
  output logic             cmd_push,
  output cmd_t             cmd
);

  logic [7:0] source_addr [SOURCE_COUNT];
  logic       active      [SOURCE_COUNT];
  logic [5:0] ann_len     [SOURCE_COUNT];
  logic [7:0] ann_packets [SOURCE_COUNT];

  logic [SOURCE_COUNT-1:0] sf_hit;
  logic [SOURCE_COUNT-1:0] an_hit;
  logic [SOURCE_COUNT-1:0] dt_hit;
  logic        sel;
  logic        accept;
  logic        ann_ok;
  logic [15:0] ann_raw;
  logic [5:0]  ann_len_sat;
  logic [7:0]  seq;
  logic        seq_ok;
  logic        finish;
  row_t        data_row;
  row_t        single_row;

  assign cfg.ready   = 1'b1;
  assign frame.ready = !cmd_full;
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    for (int s = 0; s < SOURCE_COUNT; s++) begin
      sf_hit[s] = frame.frame_id == {SINGLE_ID_HI, source_addr[s]};
      an_hit[s] = frame.frame_id == {ANNOUNCE_ID_HI, source_addr[s]};
      dt_hit[s] = frame.frame_id == {DATA_ID_HI, source_addr[s]};
    end
  end

  // source a wins when both addresses match
  assign sel = !(sf_hit[0] || an_hit[0] || dt_hit[0]);

  assign ann_ok = (frame.data_byte0 == TP_CM_BAM) && (frame.data_byte5 == PGN_LOW) &&
                  (frame.data_byte6 == PGN_MID);
  assign ann_raw = {frame.data_byte2, frame.data_byte1};
  assign ann_len_sat = (ann_raw > 16'(MESSAGE_BYTES)) ? 6'(MESSAGE_BYTES) : ann_raw[5:0];

  assign seq    = frame.data_byte0;
  assign seq_ok = active[sel] && (seq != 8'd0) && (seq <= ann_packets[sel]);
  assign finish = seq == ann_packets[sel];

  assign data_row = {frame.data_byte7, frame.data_byte6, frame.data_byte5, frame.data_byte4,
                     frame.data_byte3, frame.data_byte2, frame.data_byte1};
  assign single_row = {frame.data_byte6, frame.data_byte5, frame.data_byte4, frame.data_byte3,
                       frame.data_byte2, frame.data_byte1, frame.data_byte0};

  always_comb begin
    cmd_push    = 1'b0;
    cmd.op      = CMD_DATA;
    cmd.src     = sel;
    cmd.store   = seq <= 8'(ROWS_PER_SOURCE);
    cmd.finish  = finish;
    cmd.row     = ROW_IDX_W'(seq - 8'd1);
    cmd.length  = ann_len[sel];
    cmd.payload = data_row;
    if (accept) begin
      if (sf_hit[sel]) begin
        cmd_push    = 1'b1;
        cmd.op      = CMD_SINGLE;
        cmd.length  = SINGLE_FRAME_LEN;
        cmd.payload = single_row;
      end else if (an_hit[sel] && ann_ok) begin
        cmd_push = 1'b1;
        cmd.op   = CMD_CLEAR;
      end else if (dt_hit[sel] && seq_ok) begin
        cmd_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_addr[0] <= SOURCE_A_RESET;
      source_addr[1] <= SOURCE_B_RESET;
      for (int s = 0; s < SOURCE_COUNT; s++) begin
        active[s]      <= 1'b0;
        ann_len[s]     <= '0;
        ann_packets[s] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_SOURCE_A: source_addr[0] <= cfg.data;
          REG_SOURCE_B: source_addr[1] <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        if (an_hit[sel] && ann_ok) begin
          ann_len[sel]     <= ann_len_sat;
          ann_packets[sel] <= frame.data_byte3;
          active[sel]      <= 1'b1;
        end else if (dt_hit[sel] && seq_ok && finish) begin
          active[sel] <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/dm1bam_cmd_fifo.sv @@
// dm1bam_cmd_fifo: short command queue between the front and back ends.
// Depends on dm1bam_pkg for cmd_t and the depth.
module dm1bam_cmd_fifo import dm1bam_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  cmd_t                 entry [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   fill;
  logic                 push_ok;
  logic                 pop_ok;

  assign full    = fill == (CMD_PTR_W + 1)'(CMD_DEPTH);
  assign valid   = fill != '0;
  assign head    = entry[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok  = pop && valid;

  always_ff @(posedge clk) begin
    if (push_ok) entry[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_ok) wr_ptr <= wr_ptr + 1'b1;
      if (pop_ok) rd_ptr <= rd_ptr + 1'b1;
      case ({push_ok, pop_ok})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/core/dm1bam_back.sv @@
// dm1bam_back: row buffer, message reload and per-dtc result emission.
// Depends on dm1bam_pkg and dm1bam_if.
module dm1bam_back import dm1bam_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_pop,
  dm1bam_result_if.source result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  state_t state;

  row_t                   mem [ROW_COUNT];
  logic [ROW_COUNT-1:0]   row_valid;
  row_t                   rd_data;
  logic                   rd_ok;
  logic [ROW_IDX_W-1:0]   rd_row;
  logic                   rd_pend;
  logic [ROW_ADDR_W-1:0]  wr_base;
  logic [ROW_ADDR_W-1:0]  wr_addr;
  logic [ROW_ADDR_W-1:0]  rd_addr;

  logic [LINE_BYTES-1:0][7:0] msg;
  logic       src_r;
  logic [5:0] len_r;
  logic [3:0] present_r;
  logic [3:0] k;
  logic [3:0] last_k;
  logic [7:0] lamp_r;

  logic [5:0] len_less2;
  logic [3:0] present_raw;
  logic [3:0] present_next;
  row_t       shift_row;
  logic       out_free;
  logic       dtc_on;
  logic [7:0] lamp_now;
  logic [7:0] spn_high;
  logic [7:0] fmi_bits;

  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  assign wr_base = cmd.src ? ROW_ADDR_W'(ROWS_PER_SOURCE) : '0;
  assign wr_addr = wr_base + ROW_ADDR_W'(cmd.row);
  assign rd_addr = (src_r ? ROW_ADDR_W'(ROWS_PER_SOURCE) : '0) + ROW_ADDR_W'(rd_row);

  // slots whose four bytes lie fully inside the length
  assign len_less2   = cmd.length - 6'd2;
  assign present_raw = (cmd.length >= 6'd6) ? len_less2[5:2] : 4'd0;
  assign present_next = (present_raw > 4'(MAX_SLOTS)) ? 4'(MAX_SLOTS) : present_raw;

  assign shift_row = rd_ok ? rd_data : '0;
  assign out_free  = !result.valid || result.ready;
  assign dtc_on    = k < present_r;
  assign lamp_now  = (len_r == 6'd0) ? 8'd0 : ((k == 4'd0) ? msg[0] : lamp_r);
  assign spn_high  = msg[4] & SPN_HIGH_MASK;
  assign fmi_bits  = msg[4] & FMI_MASK;

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == CMD_DATA && cmd.store) mem[wr_addr] <= cmd.payload;
    rd_data <= mem[rd_addr];
    rd_ok   <= row_valid[rd_addr];
  end

  // rows not written since the last announce read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd_pop) begin
      if (cmd.op == CMD_CLEAR) begin
        for (int i = 0; i < ROWS_PER_SOURCE; i++) row_valid[wr_base + ROW_ADDR_W'(i)] <= 1'b0;
      end else if (cmd.op == CMD_DATA && cmd.store) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      rd_pend      <= 1'b0;
      rd_row       <= '0;
      k            <= '0;
    end else begin
      if (result.valid && result.ready && state != ST_EMIT) result.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            src_r     <= cmd.src;
            len_r     <= cmd.length;
            present_r <= present_next;
            last_k    <= (present_next == 4'd0) ? 4'd0 : present_next - 4'd1;
            k         <= '0;
            if (cmd.op == CMD_SINGLE) begin
              msg   <= (LINE_BYTES * 8)'(cmd.payload);
              state <= ST_EMIT;
            end else if (cmd.op == CMD_DATA && cmd.finish) begin
              rd_row  <= '0;
              rd_pend <= 1'b0;
              state   <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          // one row read per beat; the read data is registered before it shifts in
          rd_pend <= 1'b1;
          if (rd_pend) msg <= {shift_row, msg[LINE_BYTES-1:ROW_BYTES]};
          if (rd_row == ROW_IDX_W'(ROWS_PER_SOURCE - 1)) begin
            state <= ST_FLUSH;
          end else begin
            rd_row <= rd_row + 1'b1;
          end
        end
        ST_FLUSH: begin
          msg     <= {shift_row, msg[LINE_BYTES-1:ROW_BYTES]};
          rd_pend <= 1'b0;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            result.valid          <= 1'b1;
            result.source_select  <= src_r;
            result.message_length <= len_r;
            result.lamp_status    <= lamp_now;
            result.dtc_index      <= k;
            result.suspect_number <= dtc_on ? {spn_high[7:5], msg[3], msg[2]} : 19'd0;
            result.failure_mode   <= dtc_on ? fmi_bits[4:0] : 5'd0;
            result.dtc_present    <= dtc_on;
            result.last           <= k == last_k;
            lamp_r                <= lamp_now;
            // next slot starts four bytes on
            msg <= {32'h0, msg[LINE_BYTES-1:4]};
            if (k == last_k) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 4'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/dm1_bam_reassembly_dtc_decoder_core.sv @@
// Frames from two configured source addresses are reassembled from broadcast transport
// announce and data packets, or taken as single-frame dm1 messages, and each completed
// message is emitted as one result beat per trouble-code slot (at least one). The front end
// takes a frame every cycle while its two-entry command queue has room; the back end pops
// announce and non-final data frames while idle. A completing data frame is popped,
// then six row reads of the 7-byte-wide message buffer and one flush fill the message
// before N result beats; a single-frame dm1 skips the reads. N counts the trouble-code
// slots, 1 to 10. Result beats leave through an output register, so a result-side stall
// holds the back end. Buffer rows carry valid bits cleared by reset and by
// each announce, so there is no clearing pass after reset. Depends on dm1bam_pkg, dm1bam_if.
module dm1_bam_reassembly_dtc_decoder_core import dm1bam_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  dm1bam_cfg_if.sink      cfg,
  dm1bam_frame_if.sink    frame,
  dm1bam_result_if.source result
);

  logic cmd_push;
  logic cmd_full;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t push_cmd;
  cmd_t head_cmd;

  dm1bam_front u_front (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .cfg      (cfg),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  dm1bam_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .full     (cmd_full),
    .valid    (cmd_valid),
    .head     (head_cmd),
    .pop      (cmd_pop)
  );

  dm1bam_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  a_absent_slot: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.dtc_present |->
      result.suspect_number == 19'd0 && result.failure_mode == 5'd0 &&
      result.dtc_index == 4'd0 && result.last)
    else $error("absent slot beat carries data or is not the only beat");

  a_slot_in_length: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.dtc_present |->
      ({1'b0, result.dtc_index, 2'b00} + 7'd6) <= {1'b0, result.message_length})
    else $error("present slot lies beyond message length");
`endif

endmodule
